// File: design/rle4bd_pkg.sv
package rle4bd_pkg;

	// Field widths fixed by the stream and register formats
	localparam int GEOM_W     = 11;
	localparam int DLEN_W     = 21;
	localparam int POS_W      = 21;
	localparam int INDEX_W    = 20;
	localparam int RUN_W      = 8;
	localparam int COLOR_W    = 4;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH  = 2'd2;

	// Parse phases
	localparam logic [2:0] PH_COUNT  = 3'd0;
	localparam logic [2:0] PH_COLOR  = 3'd1;
	localparam logic [2:0] PH_ESCAPE = 3'd2;
	localparam logic [2:0] PH_DX     = 3'd3;
	localparam logic [2:0] PH_DY     = 3'd4;
	localparam logic [2:0] PH_ABS    = 3'd5;
	localparam logic [2:0] PH_PAD    = 3'd6;

	// Escape codes
	localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
	localparam logic [BYTE_W-1:0] ESC_EOI   = 8'd1;
	localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

	localparam logic KIND_RUN  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

	typedef struct packed {
		logic              start_image;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] start_index;
		logic [RUN_W-1:0]   run_length;
		logic [COLOR_W-1:0] first_color;
		logic [COLOR_W-1:0] second_color;
		logic               clipped;
	} result_t;

endpackage

// File: design/rle4bd_item_if.sv
interface rle4bd_item_if import rle4bd_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/rle4bd_res_if.sv
interface rle4bd_res_if import rle4bd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/rle4bd_cfg_if.sv
interface rle4bd_cfg_if import rle4bd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/rle4bd_cfg.sv
module rle4bd_cfg import rle4bd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int WW         = $clog2(MAX_WIDTH + 1),
	parameter int HW         = $clog2(MAX_HEIGHT + 1),
	parameter int TW         = WW + HW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic [WW-1:0]         eff_width,
	output logic [TW-1:0]         eff_total,
	output logic [DLEN_W-1:0]     data_length
);

	logic [WW-1:0]     width_q;
	logic [HW-1:0]     height_q;
	logic [TW-1:0]     total_q;
	logic [DLEN_W-1:0] dlen_q;

	logic [GEOM_W-1:0] wr_geom;
	logic [WW-1:0]     new_width;
	logic [HW-1:0]     new_height;

	assign wr_geom = wr_data[GEOM_W-1:0];

	// clamp the written geometry into 1..MAX
	always_comb begin
		if (32'(wr_geom) > MAX_WIDTH)
			new_width = WW'(MAX_WIDTH);
		else if (wr_geom == '0)
			new_width = WW'(1);
		else
			new_width = WW'(wr_geom);

		if (32'(wr_geom) > MAX_HEIGHT)
			new_height = HW'(MAX_HEIGHT);
		else if (wr_geom == '0)
			new_height = HW'(1);
		else
			new_height = HW'(wr_geom);
	end

	// pixel total is refreshed with the write itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(1);
			height_q <= HW'(1);
			total_q  <= TW'(1);
			dlen_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH: begin
					width_q <= new_width;
					total_q <= TW'(new_width) * TW'(height_q);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= new_height;
					total_q  <= TW'(width_q) * TW'(new_height);
				end
				REG_DATA_LENGTH: begin
					dlen_q <= wr_data[DLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign eff_width   = width_q;
	assign eff_total   = total_q;
	assign data_length = dlen_q;

endmodule

// File: design/rle4bd_parse.sv
module rle4bd_parse import rle4bd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int WW         = $clog2(MAX_WIDTH + 1),
	parameter int HW         = $clog2(MAX_HEIGHT + 1),
	parameter int TW         = WW + HW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_vld,
	input  item_t             item,
	input  logic [WW-1:0]     eff_width,
	input  logic [TW-1:0]     eff_total,
	input  logic [DLEN_W-1:0] data_length,
	output logic              res_vld,
	output result_t           res
);

	localparam int CW = (TW > POS_W) ? TW + 1 : POS_W + 1;
	localparam int SW = ((BYTE_W + WW > POS_W) ? BYTE_W + WW : POS_W) + 2;

	logic [2:0]        phase_q, phase_d;
	logic [RUN_W-1:0]  pend_q, pend_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [DLEN_W-1:0] bytes_q, bytes_d;
	logic [BYTE_W-1:0] dx_q, dx_d;
	logic              fin_q, fin_d;

	logic [BYTE_W-1:0]  b;
	logic [COLOR_W-1:0] hi_nib, lo_nib;
	logic [RUN_W-1:0]   abs_n, run_len;
	logic [CW-1:0]      pos_ext, total_ext, room;
	logic [RUN_W-1:0]   kept;
	logic [POS_W:0]     run_end;
	logic [POS_W-1:0]   run_pos;
	logic [SW-1:0]      delta_sum;
	logic [POS_W-1:0]   delta_pos;
	logic               at_end;
	result_t            run_res;

	assign b      = item.data_byte;
	assign hi_nib = b[7:4];
	assign lo_nib = b[3:0];

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		pos_d   = pos_q;
		bytes_d = bytes_q;
		dx_d    = dx_q;
		fin_d   = fin_q;
		if (item.start_image) begin
			phase_d = PH_COUNT;
			pend_d  = '0;
			pos_d   = '0;
			bytes_d = '0;
			dx_d    = '0;
			fin_d   = 1'b0;
		end

		// run emission, shared by encoded and absolute runs
		abs_n     = (pend_d >= RUN_W'(2)) ? RUN_W'(2) : RUN_W'(1);
		run_len   = (phase_d == PH_COLOR) ? pend_d : abs_n;
		pos_ext   = CW'(pos_d);
		total_ext = CW'(eff_total);
		at_end    = pos_ext >= total_ext;
		room      = at_end ? '0 : total_ext - pos_ext;
		kept      = (room > CW'(run_len)) ? run_len : room[RUN_W-1:0];
		run_end   = (POS_W+1)'(pos_d) + (POS_W+1)'(run_len);
		run_pos   = run_end[POS_W] ? POS_SAT : run_end[POS_W-1:0];

		run_res.kind         = KIND_RUN;
		run_res.start_index  = pos_d[INDEX_W-1:0];
		run_res.run_length   = kept;
		run_res.first_color  = hi_nib;
		run_res.second_color = (run_len == RUN_W'(1)) ? '0 : lo_nib;
		run_res.clipped      = kept < run_len;

		delta_sum = SW'(pos_d) + SW'(b) * SW'(eff_width) + SW'(dx_d);
		delta_pos = (delta_sum > SW'(POS_SAT)) ? POS_SAT : delta_sum[POS_W-1:0];

		res_vld = 1'b0;
		res     = '0;

		if (!fin_d) begin
			if (phase_d == PH_COUNT && (bytes_d >= data_length || at_end)) begin
				fin_d    = 1'b1;
				res_vld  = 1'b1;
				res.kind = KIND_DONE;
			end else begin
				if (bytes_d != POS_SAT)
					bytes_d = bytes_d + DLEN_W'(1);
				case (phase_d)
					PH_COUNT: begin
						pend_d  = b;
						phase_d = (b != '0) ? PH_COLOR : PH_ESCAPE;
					end
					PH_COLOR: begin
						res_vld = 1'b1;
						res     = run_res;
						pos_d   = run_pos;
						pend_d  = '0;
						phase_d = PH_COUNT;
					end
					PH_ESCAPE: begin
						if (b == ESC_EOL) begin
							phase_d = PH_COUNT;
						end else if (b == ESC_EOI) begin
							fin_d    = 1'b1;
							phase_d  = PH_COUNT;
							res_vld  = 1'b1;
							res.kind = KIND_DONE;
						end else if (b == ESC_DELTA) begin
							phase_d = PH_DX;
						end else begin
							pend_d  = b;
							phase_d = PH_ABS;
						end
					end
					PH_DX: begin
						dx_d    = b;
						phase_d = PH_DY;
					end
					PH_DY: begin
						pos_d   = delta_pos;
						phase_d = PH_COUNT;
					end
					PH_ABS: begin
						res_vld = 1'b1;
						res     = run_res;
						pos_d   = run_pos;
						pend_d  = (pend_d >= abs_n) ? pend_d - abs_n : '0;
						// word alignment: odd byte count takes a pad byte
						if (pend_d == '0)
							phase_d = bytes_d[0] ? PH_PAD : PH_COUNT;
					end
					default: begin
						phase_d = PH_COUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pend_q  <= '0;
			pos_q   <= '0;
			bytes_q <= '0;
			dx_q    <= '0;
			fin_q   <= 1'b0;
		end else if (item_vld) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			pos_q   <= pos_d;
			bytes_q <= bytes_d;
			dx_q    <= dx_d;
			fin_q   <= fin_d;
		end
	end

endmodule

// File: design/rle4_bitmap_decoder_top.sv
// RLE4 bitmap stream decoder.
// items:   one compressed byte per transfer (data_byte), with start_image
//          set on the first byte of a new image to clear the parse state.
// results: zero or one result per byte: a clipped pixel run (kind 0) with
//          start index, length and the two alternating colors, or the
//          end-of-decoding marker (kind 1).
// cfg:     writes image_width (0), image_height (1), data_length (2);
//          always ready; to be written only while the decoder is idle (not enforced by the block).
// Throughput: one byte per cycle while results are accepted. A byte sits
// in the input register while the parser updates its state and the result
// register loads, both on the edge that moves the byte on.
// The per-byte work is one parse-state update plus, for a delta escape,
// one 8-bit by row-width multiply-add.
// Reset (arst_n low) clears the parse state and both pipeline valids and
// sets width 1, height 1, data_length 0.
// A stalled result holds in the result register; the input register
// still takes one more byte, then items.ready drops until results drain.
module rle4_bitmap_decoder_top import rle4bd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic         clk,
	input  logic         arst_n,
	rle4bd_item_if.sink  items,
	rle4bd_res_if.source results,
	rle4bd_cfg_if.sink   cfg
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int TW = WW + HW;

	logic              in_vld_s1;
	item_t             in_s1;
	logic              out_vld_s2;
	result_t           out_s2;
	logic              advance;
	logic              res_vld;
	result_t           res;
	logic [WW-1:0]     eff_width;
	logic [TW-1:0]     eff_total;
	logic [DLEN_W-1:0] data_length;

	assign cfg.ready = 1'b1;

	rle4bd_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WW        (WW),
		.HW        (HW),
		.TW        (TW)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg.valid),
		.wr_index   (cfg.index),
		.wr_data    (cfg.data),
		.eff_width  (eff_width),
		.eff_total  (eff_total),
		.data_length(data_length)
	);

	// byte moves on when the result register is free or draining
	assign advance     = in_vld_s1 && (!out_vld_s2 || results.ready);
	assign items.ready = !in_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_vld_s1 <= 1'b0;
		else if (items.ready)
			in_vld_s1 <= items.valid;
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid)
			in_s1 <= items.data;
	end

	rle4bd_parse #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WW        (WW),
		.HW        (HW),
		.TW        (TW)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_vld   (advance),
		.item       (in_s1),
		.eff_width  (eff_width),
		.eff_total  (eff_total),
		.data_length(data_length),
		.res_vld    (res_vld),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_s2 <= 1'b0;
		else if (advance)
			out_vld_s2 <= res_vld;
		else if (results.ready)
			out_vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld)
			out_s2 <= res;
	end

	assign results.valid = out_vld_s2;
	assign results.data  = out_s2;

endmodule

// File: bench/tb_rle4_bitmap_decoder_top.sv
`timescale 1ns / 1ps

module tb_rle4_bitmap_decoder_top;
	import rle4bd_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;

	typedef struct {
		item_t it;
		bit    hold;	// wait for all runs to drain before this byte
	} queued_byte_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY, RX_HOLD} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	rle4bd_item_if items_ch ();
	rle4bd_res_if  results_ch ();
	rle4bd_cfg_if  cfg_ch ();

	rle4_bitmap_decoder_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	queued_byte_t stream_q[$];
	result_t      pending_runs[$];
	int           err_count = 0;
	bit           runs_drained = 1'b1;

	// stream generation state
	bit fresh_image = 1'b0;
	bit hold_next = 1'b0;
	int stream_len = 0;
	int phase_bytes = 0;

	// sender bursts, receiver stall pattern
	int       burst_left = 0;
	int       gap_left = 0;
	int       win_left = 0;
	rx_mode_e rx_mode = RX_OPEN;

	// decoder shadow: registers and parse state
	logic [GEOM_W-1:0] img_width, img_height;
	logic [DLEN_W-1:0] img_bytes;
	logic [2:0]        sh_phase;
	logic [7:0]        sh_count;
	logic [POS_W-1:0]  sh_pos;
	logic [DLEN_W-1:0] sh_used;
	logic [7:0]        sh_dx;
	logic              sh_done;

	function automatic longint row_pixels();
		longint w;
		w = img_width;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic longint image_pixels();
		longint h;
		h = img_height;
		if (h < 1) h = 1;
		if (h > MAX_H) h = MAX_H;
		return row_pixels() * h;
	endfunction

	function automatic logic [POS_W-1:0] sat21(longint v);
		return (v > longint'(POS_SAT)) ? POS_SAT : v[POS_W-1:0];
	endfunction

	task automatic clear_parse();
		sh_phase = PH_COUNT;
		sh_count = '0;
		sh_pos = '0;
		sh_used = '0;
		sh_dx = '0;
		sh_done = 1'b0;
	endtask

	task automatic push_finish();
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		pending_runs.push_back(r);
	endtask

	task automatic emit_run(longint len, logic [3:0] hi, logic [3:0] lo);
		result_t r;
		longint  total, room, kept;
		total = image_pixels();
		room = (sh_pos < total) ? total - sh_pos : 0;
		kept = (len < room) ? len : room;
		r.kind = KIND_RUN;
		r.start_index = sh_pos[INDEX_W-1:0];
		r.run_length = kept[RUN_W-1:0];
		r.first_color = hi;
		r.second_color = (len == 1) ? 4'h0 : lo;
		r.clipped = (kept < len);
		pending_runs.push_back(r);
		sh_pos = sat21(longint'(sh_pos) + len);
	endtask

	task automatic decode_byte(item_t it);
		logic [7:0] b;
		int         n;
		b = it.data_byte;
		if (it.start_image)
			clear_parse();
		if (sh_done)
			return;
		// end of stream is only looked at where a count byte is due
		if (sh_phase == PH_COUNT && (sh_used >= img_bytes || sh_pos >= image_pixels())) begin
			sh_done = 1'b1;
			push_finish();
			return;
		end
		sh_used = sat21(longint'(sh_used) + 1);
		case (sh_phase)
			PH_COUNT: begin
				sh_count = b;
				sh_phase = (b != 0) ? PH_COLOR : PH_ESCAPE;
			end
			PH_COLOR: begin
				emit_run(sh_count, b[7:4], b[3:0]);
				sh_count = '0;
				sh_phase = PH_COUNT;
			end
			PH_ESCAPE: begin
				if (b == ESC_EOL) begin
					sh_phase = PH_COUNT;
				end else if (b == ESC_EOI) begin
					sh_done = 1'b1;
					sh_phase = PH_COUNT;
					push_finish();
				end else if (b == ESC_DELTA) begin
					sh_phase = PH_DX;
				end else begin
					sh_count = b;
					sh_phase = PH_ABS;
				end
			end
			PH_DX: begin
				sh_dx = b;
				sh_phase = PH_DY;
			end
			PH_DY: begin
				sh_pos = sat21(longint'(sh_pos) + longint'(b) * row_pixels() + sh_dx);
				sh_phase = PH_COUNT;
			end
			PH_ABS: begin
				n = (sh_count >= 2) ? 2 : 1;
				emit_run(n, b[7:4], b[3:0]);
				sh_count = (sh_count >= n) ? 8'(sh_count - n) : 8'd0;
				if (sh_count == 0)
					sh_phase = sh_used[0] ? PH_PAD : PH_COUNT;
			end
			default: begin
				sh_phase = PH_COUNT;
			end
		endcase
	endtask

	task automatic check_result(result_t got);
		result_t exp;
		if (pending_runs.size() == 0) begin
			$error("result with no expectation: kind %0d start_index %0d run_length %0d",
				got.kind, got.start_index, got.run_length);
			err_count++;
			return;
		end
		exp = pending_runs.pop_front();
		if (got.kind !== exp.kind) begin
			$error("kind mismatch: expected %0d, actual %0d", exp.kind, got.kind);
			err_count++;
		end
		if (got.start_index !== exp.start_index) begin
			$error("start_index mismatch: expected %0d, actual %0d",
				exp.start_index, got.start_index);
			err_count++;
		end
		if (got.run_length !== exp.run_length) begin
			$error("run_length mismatch: expected %0d, actual %0d",
				exp.run_length, got.run_length);
			err_count++;
		end
		if (got.first_color !== exp.first_color) begin
			$error("first_color mismatch: expected %0d, actual %0d",
				exp.first_color, got.first_color);
			err_count++;
		end
		if (got.second_color !== exp.second_color) begin
			$error("second_color mismatch: expected %0d, actual %0d",
				exp.second_color, got.second_color);
			err_count++;
		end
		if (got.clipped !== exp.clipped) begin
			$error("clipped mismatch: expected %0d, actual %0d", exp.clipped, got.clipped);
			err_count++;
		end
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (items_ch.valid && items_ch.ready)
				decode_byte(items_ch.data);
			if (!items_ch.valid || items_ch.ready) begin
				if (burst_left == 0) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
				// a held byte goes only after an idle cycle with every run drained
				if (burst_left > 0 && stream_q.size() > 0 &&
					(!stream_q[0].hold || (runs_drained && !items_ch.valid))) begin
					items_ch.valid <= 1'b1;
					items_ch.data <= stream_q[0].it;
					void'(stream_q.pop_front());
					burst_left--;
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			check_result(results_ch.data);
		if (win_left == 0) begin
			win_left = $urandom_range(20, 150);
			rx_mode = rx_mode_e'($urandom_range(0, 4));
		end else begin
			win_left--;
		end
		case (rx_mode)
			RX_OPEN:   results_ch.ready <= 1'b1;
			RX_COIN:   results_ch.ready <= 1'($urandom_range(0, 1));
			RX_EVERY4: results_ch.ready <= (win_left % 4 == 0);
			RX_MOSTLY: results_ch.ready <= ($urandom_range(0, 7) != 0);
			default:   results_ch.ready <= (win_left < 4);
		endcase
	end

	always @(negedge clk)
		runs_drained = (pending_runs.size() == 0);

	task automatic push_byte(logic [7:0] b);
		queued_byte_t e;
		e.it.start_image = fresh_image;
		e.it.data_byte = b;
		e.hold = hold_next;
		if (fresh_image)
			stream_len = 0;
		fresh_image = 1'b0;
		hold_next = 1'b0;
		stream_len++;
		phase_bytes++;
		stream_q.push_back(e);
	endtask

	// one image: start byte, then mostly well-formed tokens, some noise
	task automatic gen_image(int max_bytes);
		int first, sel, n, k;
		bit stop;
		first = phase_bytes;
		stop = 1'b0;
		fresh_image = 1'b1;
		hold_next = ($urandom_range(0, 7) == 0);
		while (!stop && phase_bytes - first < max_bytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(1, 16)));
				push_byte(8'($urandom));
			end else if (sel < 48) begin
				push_byte(8'h00);
				push_byte(ESC_EOL);
			end else if (sel < 52) begin
				push_byte(8'h00);
				push_byte(ESC_EOI);
				stop = 1'b1;
				if ($urandom_range(0, 3) == 0)
					push_byte(8'($urandom));	// ignored after finish
			end else if (sel < 66) begin
				push_byte(8'h00);
				push_byte(ESC_DELTA);
				push_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom));
				push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
			end else if (sel < 92) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
				push_byte(8'h00);
				push_byte(8'(n));
				for (k = 0; k < (n + 1) / 2; k++)
					push_byte(8'($urandom));
				if (stream_len % 2 != 0)
					push_byte(8'($urandom));
			end else begin
				if ($urandom_range(0, 15) == 0)
					fresh_image = 1'b1;
				push_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(stream_q.size() == 0 && !items_ch.valid && pending_runs.size() == 0));
		// bytes that give no result may still be in the parser
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_IMAGE_WIDTH:  img_width = val[GEOM_W-1:0];
			REG_IMAGE_HEIGHT: img_height = val[GEOM_W-1:0];
			REG_DATA_LENGTH:  img_bytes = val[DLEN_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int                p;
		logic [GEOM_W-1:0] w, h;
		logic [DLEN_W-1:0] len;

		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		results_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		img_width = 11'd1;
		img_height = 11'd1;
		img_bytes = '0;
		clear_parse();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry with zero length: first byte finishes, second is ignored
		push_byte(8'h00);
		push_byte(8'hFF);
		wait_idle();

		write_reg(REG_IMAGE_WIDTH, 21'd16);
		write_reg(REG_IMAGE_HEIGHT, 21'd4);
		write_reg(REG_DATA_LENGTH, POS_SAT);
		@(negedge clk);
		fresh_image = 1'b1;
		push_byte(8'h05); push_byte(8'hA3);
		push_byte(8'h01); push_byte(8'hFF);	// single pixel
		push_byte(8'h00); push_byte(ESC_EOL);
		push_byte(8'h00); push_byte(ESC_DELTA); push_byte(8'h03); push_byte(8'h01);
		push_byte(8'hFF); push_byte(8'h0F);	// clipped at image end
		push_byte(8'h07);			// position past image: finish
		fresh_image = 1'b1;
		push_byte(8'h00); push_byte(ESC_EOI);
		// absolute run over the last pixel, then runs fully past the end, pad
		fresh_image = 1'b1;
		hold_next = 1'b1;
		push_byte(8'h00); push_byte(ESC_DELTA); push_byte(8'h0F); push_byte(8'h03);
		push_byte(8'h00); push_byte(8'h06);
		push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'h44);
		push_byte(8'h01);
		wait_idle();

		for (p = 0; p < 10; p++) begin
			case (p)
				0: begin w = 11'd16; h = 11'd4; len = POS_SAT; end
				1: begin w = 11'd0; h = 11'd0; len = POS_SAT; end
				2: begin w = 11'd2047; h = 11'd2047; len = POS_SAT; end
				3: begin w = 11'd1024; h = 11'd1; len = 21'($urandom_range(0, 200)); end
				4: begin w = 11'd1; h = 11'd1024; len = 21'($urandom_range(0, 3)); end
				default: begin
					w = 11'($urandom_range(1, 64));
					h = 11'($urandom_range(1, 16));
					case ($urandom_range(0, 3))
						0: len = POS_SAT;
						1: len = 21'($urandom_range(1, 300));
						2: len = 21'($urandom);
						default: len = 21'($urandom_range(0, 20));
					endcase
				end
			endcase
			write_reg(REG_IMAGE_WIDTH, 21'(w));
			write_reg(REG_IMAGE_HEIGHT, 21'(h));
			write_reg(REG_DATA_LENGTH, len);
			@(negedge clk);
			phase_bytes = 0;
			while (phase_bytes < 130)
				gen_image($urandom_range(6, 60));
			wait_idle();
		end

		if (err_count == 0 && pending_runs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
